// ----- design/icv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package icv_pkg;

    // Field and register widths
    localparam int PIX_W = 8;
    localparam int CFG_W = 24;
    localparam int IDX_W = 3;
    localparam int GEO_W = 11;

    // Arithmetic widths of the filter path
    localparam int PROD_W = 17;
    localparam int ROWS_W = 19;
    localparam int ACC_W  = 21;
    localparam int REM_W  = 19;
    localparam int DVS_W  = 11;
    localparam int QUO_W  = 9;

    // Output buffer
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_KTOP   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_KMID   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_KBOT   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] KTOP_RST   = 24'h010201;
    localparam logic [CFG_W-1:0] KMID_RST   = 24'h020402;
    localparam logic [CFG_W-1:0] KBOT_RST   = 24'h010201;
    localparam logic [GEO_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [GEO_W-1:0] HEIGHT_RST = 11'd480;

    // Geometry limits
    localparam logic [GEO_W-1:0] MIN_DIM    = 11'd3;
    localparam logic [GEO_W-1:0] MAX_HEIGHT = 11'd1024;

    // Where a result value comes from
    typedef logic [2:0] t_kind;
    localparam t_kind K_COL0     = 3'd0;
    localparam t_kind K_CENTER   = 3'd1;
    localparam t_kind K_FILTER   = 3'd2;
    localparam t_kind K_DRAIN_UP = 3'd3;
    localparam t_kind K_DRAIN_LO = 3'd4;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] in_pixel;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             frame_end;
    } t_out;

    // Token handed from cell to cell in the divider chain
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             frame_end;
        logic             use_div;
        logic             is_zero;
        logic [PIX_W-1:0] val;
        logic [REM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } t_tok;

endpackage
`default_nettype wire

// ----- design/icv_line_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
module icv_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_lo_wr_en,
    input  wire logic [AW-1:0] i_lo_wr_addr,
    input  wire logic [7:0]    i_lo_wr_data,
    input  wire logic [AW-1:0] i_lo_rd_addr,
    output logic      [7:0]    o_lo_q,
    input  wire logic          i_up_wr_en,
    input  wire logic [AW-1:0] i_up_wr_addr,
    input  wire logic [AW-1:0] i_up_a_addr,
    input  wire logic [AW-1:0] i_up_b_addr,
    output logic      [7:0]    o_up_a,
    output logic      [7:0]    o_up_b
);

    logic [7:0] r_lo_mem [DEPTH];
    logic [7:0] r_up_mem [DEPTH];
    logic [7:0] r_lo_q;
    logic [7:0] r_up_a_q;
    logic [7:0] r_up_b_q;
    logic [7:0] r_fwd_data;
    logic       r_fwd_a;
    logic       r_fwd_b;

    // Lower line: read-old on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_lo_wr_en) begin
            r_lo_mem[i_lo_wr_addr] <= i_lo_wr_data;
        end
        r_lo_q <= r_lo_mem[i_lo_rd_addr];
    end

    // Upper line takes the registered lower-line read data
    always_ff @(posedge i_clk) begin
        if (i_up_wr_en) begin
            r_up_mem[i_up_wr_addr] <= r_lo_q;
        end
        r_up_a_q   <= r_up_mem[i_up_a_addr];
        r_up_b_q   <= r_up_mem[i_up_b_addr];
        r_fwd_data <= r_lo_q;
    end

    // Bypass a write that lands on the address being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            r_fwd_a <= i_up_wr_en && (i_up_a_addr == i_up_wr_addr);
            r_fwd_b <= i_up_wr_en && (i_up_b_addr == i_up_wr_addr);
        end
    end

    assign o_lo_q = r_lo_q;
    assign o_up_a = r_fwd_a ? r_fwd_data : r_up_a_q;
    assign o_up_b = r_fwd_b ? r_fwd_data : r_up_b_q;

endmodule
`default_nettype wire

// ----- design/icv_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module icv_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire icv_pkg::t_tok i_tok,
    output icv_pkg::t_tok      o_tok
);

    logic [icv_pkg::REM_W:0] w_rem;
    logic [icv_pkg::REM_W:0] w_sub;
    icv_pkg::t_tok           n_tok;
    icv_pkg::t_tok           r_tok;

    // One restoring step: try the divisor at this bit weight
    always_comb begin
        w_rem = {1'b0, i_tok.rem};
        w_sub = (icv_pkg::REM_W + 1)'(i_tok.dvs) << SHIFT;
        n_tok = i_tok;
        if (i_tok.use_div && (w_rem >= w_sub)) begin
            n_tok.rem        = icv_pkg::REM_W'(w_rem - w_sub);
            n_tok.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ----- design/icv_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module icv_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire icv_pkg::t_out i_data,
    input  wire logic          i_pop,
    output logic               o_valid,
    output icv_pkg::t_out      o_data
);

    icv_pkg::t_out                r_mem [icv_pkg::FIFO_DEPTH];
    logic [icv_pkg::FIFO_AW-1:0]  r_wr;
    logic [icv_pkg::FIFO_AW-1:0]  r_rd;
    logic [icv_pkg::FIFO_AW:0]    r_cnt;

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

// ----- design/image_convolution_3x3.sv -----
// Path: a result beat passes stages 1 to 4, the divider cells and the output buffer
// after the input beat that produces it (on top of the raster lag of one row plus one pixel).
// Throughput: one beat per cycle while o_in_ready is high, set by one line-memory access per
// column and a nine-cell divider chain that takes a new quotient every cycle; 32-beat output buffer.
// Reset: counters, window, pipeline and buffer clear, registers reload defaults;
// line memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module image_convolution_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [icv_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [icv_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire icv_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output icv_pkg::t_out                  o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    // Configuration
    logic [icv_pkg::CFG_W-1:0] r_ktop, r_kmid, r_kbot;
    logic [icv_pkg::GEO_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktop   <= icv_pkg::KTOP_RST;
            r_kmid   <= icv_pkg::KMID_RST;
            r_kbot   <= icv_pkg::KBOT_RST;
            r_width  <= icv_pkg::WIDTH_RST;
            r_height <= icv_pkg::HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                icv_pkg::CFG_KTOP:   r_ktop   <= i_cfg_wdata;
                icv_pkg::CFG_KMID:   r_kmid   <= i_cfg_wdata;
                icv_pkg::CFG_KBOT:   r_kbot   <= i_cfg_wdata;
                icv_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata[icv_pkg::GEO_W-1:0];
                icv_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata[icv_pkg::GEO_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped geometry
    logic [WW-1:0]             w_w;
    logic [icv_pkg::GEO_W-1:0] w_h;

    always_comb begin
        if (r_width < icv_pkg::MIN_DIM) begin
            w_w = WW'(3);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_width);
        end
        if (r_height < icv_pkg::MIN_DIM) begin
            w_h = icv_pkg::MIN_DIM;
        end else if (r_height > icv_pkg::MAX_HEIGHT) begin
            w_h = icv_pkg::MAX_HEIGHT;
        end else begin
            w_h = r_height;
        end
    end

    // Coefficients and their absolute sum
    logic [icv_pkg::CFG_W-1:0] w_krow [3];
    logic signed [7:0]         w_coef [9];
    logic [8:0]                w_abs  [9];
    logic [icv_pkg::DVS_W-1:0] n_total, r_total;

    always_comb begin
        w_krow[0] = r_ktop;
        w_krow[1] = r_kmid;
        w_krow[2] = r_kbot;
        n_total   = '0;
        for (int t = 0; t < 9; t++) begin
            w_coef[t] = w_krow[t / 3][8 * (t % 3) +: 8];
            w_abs[t]  = w_coef[t][7] ? 9'(9'd256 - {1'b0, w_coef[t]}) : {1'b0, w_coef[t]};
            n_total   = n_total + icv_pkg::DVS_W'(w_abs[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
    end

    // Raster position and pending tail
    logic [CW-1:0]             r_col, n_col;
    logic [9:0]                r_row, n_row;
    logic [PW-1:0]             r_pend, n_pend;
    logic                      w_acc;
    logic                      w_is_pix;
    logic [WW-1:0]             w_col_inc;
    logic [icv_pkg::GEO_W-1:0] w_row_inc;
    logic [WW-1:0]             w_wm1;
    logic [PW-1:0]             w_drain_ofs;
    logic                      s0_emit;
    logic                      s0_fe;
    icv_pkg::t_kind            s0_kind;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_is_pix    = !i_in_data.action;
    assign w_col_inc   = WW'(r_col) + WW'(1);
    assign w_row_inc   = {1'b0, r_row} + 11'd1;
    assign w_wm1       = w_w - WW'(1);
    assign w_drain_ofs = PW'(w_w) - r_pend;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_pend  = r_pend;
        s0_emit = 1'b0;
        s0_fe   = 1'b0;
        s0_kind = icv_pkg::K_CENTER;
        if (w_acc) begin
            if (w_is_pix) begin
                n_pend = '0;
                // Right border pixel of the row before last
                if (r_row >= 10'd2 && r_col == '0) begin
                    s0_emit = 1'b1;
                    s0_kind = icv_pkg::K_COL0;
                end
                if (r_row >= 10'd1 && r_col != '0) begin
                    s0_emit = 1'b1;
                    s0_kind = (r_row >= 10'd2 && r_col >= CW'(2)) ? icv_pkg::K_FILTER
                                                                   : icv_pkg::K_CENTER;
                end
                if (w_col_inc >= w_w) begin
                    n_col = '0;
                    if (w_row_inc >= w_h) begin
                        n_row  = '0;
                        n_pend = PW'(w_w) + PW'(1);
                    end else begin
                        n_row = w_row_inc[9:0];
                    end
                end else begin
                    n_col = w_col_inc[CW-1:0];
                end
            end else if (r_pend != '0) begin
                s0_emit = 1'b1;
                s0_kind = (r_pend > PW'(w_w)) ? icv_pkg::K_DRAIN_UP : icv_pkg::K_DRAIN_LO;
                s0_fe   = (r_pend == PW'(1));
                n_pend  = r_pend - PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
        end
    end

    // Stage 1 token: beat accepted, memory read in flight
    logic                      r_s1_vld;
    logic                      r_s1_pix;
    logic                      r_s1_emit;
    logic                      r_s1_fe;
    icv_pkg::t_kind            r_s1_kind;
    logic [7:0]                r_s1_data;
    logic [CW-1:0]             r_s1_col;

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= w_is_pix;
        r_s1_emit <= s0_emit;
        r_s1_fe   <= s0_fe;
        r_s1_kind <= s0_kind;
        r_s1_data <= i_in_data.in_pixel;
        r_s1_col  <= r_col;
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
        end
    end

    // Line memories
    logic [7:0] w_lo_q, w_up_a, w_up_b;

    icv_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lo_wr_en   (w_acc && w_is_pix),
        .i_lo_wr_addr (r_col),
        .i_lo_wr_data (i_in_data.in_pixel),
        .i_lo_rd_addr (w_is_pix ? r_col : w_drain_ofs[CW-1:0]),
        .o_lo_q       (w_lo_q),
        .i_up_wr_en   (r_s1_vld && r_s1_pix),
        .i_up_wr_addr (r_s1_col),
        .i_up_a_addr  (r_col),
        .i_up_b_addr  (w_wm1[CW-1:0]),
        .o_up_a       (w_up_a),
        .o_up_b       (w_up_b)
    );

    // Window shift and result source
    logic [7:0]                  r_win [9];
    logic [7:0]                  n_win [9];
    logic [7:0]                  s1_val;
    logic signed [icv_pkg::PROD_W-1:0] s1_prod [9];

    always_comb begin
        n_win = r_win;
        if (r_s1_vld && r_s1_pix) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r * 3]     = r_win[r * 3 + 1];
                n_win[r * 3 + 1] = r_win[r * 3 + 2];
            end
            n_win[2] = w_up_a;
            n_win[5] = w_lo_q;
            n_win[8] = r_s1_data;
        end
        case (r_s1_kind)
            icv_pkg::K_COL0:     s1_val = w_up_b;
            icv_pkg::K_DRAIN_UP: s1_val = w_up_b;
            icv_pkg::K_DRAIN_LO: s1_val = w_lo_q;
            default:             s1_val = n_win[4];
        endcase
        for (int t = 0; t < 9; t++) begin
            s1_prod[t] = $signed({1'b0, n_win[t]}) * w_coef[t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 9; t++) begin
                r_win[t] <= '0;
            end
        end else begin
            r_win <= n_win;
        end
    end

    // Stage 2: products
    logic                              r_s2_vld, r_s2_emit, r_s2_fe, r_s2_div;
    logic [7:0]                        r_s2_val;
    logic signed [icv_pkg::PROD_W-1:0] r_s2_prod [9];

    always_ff @(posedge i_clk) begin
        r_s2_emit <= r_s1_emit;
        r_s2_fe   <= r_s1_fe;
        r_s2_div  <= (r_s1_kind == icv_pkg::K_FILTER);
        r_s2_val  <= s1_val;
        r_s2_prod <= s1_prod;
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // Stage 3: row sums
    logic                              r_s3_vld, r_s3_emit, r_s3_fe, r_s3_div;
    logic [7:0]                        r_s3_val;
    logic signed [icv_pkg::ROWS_W-1:0] r_s3_row [3];

    always_ff @(posedge i_clk) begin
        r_s3_emit <= r_s2_emit;
        r_s3_fe   <= r_s2_fe;
        r_s3_div  <= r_s2_div;
        r_s3_val  <= r_s2_val;
        for (int r = 0; r < 3; r++) begin
            r_s3_row[r] <= icv_pkg::ROWS_W'(r_s2_prod[r * 3])
                         + icv_pkg::ROWS_W'(r_s2_prod[r * 3 + 1])
                         + icv_pkg::ROWS_W'(r_s2_prod[r * 3 + 2]);
        end
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    // Stage 4: full sum, magnitude, divider setup
    logic signed [icv_pkg::ACC_W-1:0] w_acc_sum;
    logic        [icv_pkg::ACC_W-1:0] w_acc_mag;
    icv_pkg::t_tok                    n_s4_tok, r_s4_tok;

    always_comb begin
        w_acc_sum = icv_pkg::ACC_W'(r_s3_row[0]) + icv_pkg::ACC_W'(r_s3_row[1])
                  + icv_pkg::ACC_W'(r_s3_row[2]);
        w_acc_mag = w_acc_sum[icv_pkg::ACC_W-1] ? icv_pkg::ACC_W'(-w_acc_sum)
                                                : icv_pkg::ACC_W'(w_acc_sum);
        n_s4_tok.valid     = r_s3_vld;
        n_s4_tok.emit      = r_s3_emit;
        n_s4_tok.frame_end = r_s3_fe;
        n_s4_tok.use_div   = r_s3_div;
        n_s4_tok.is_zero   = (r_total == '0);
        n_s4_tok.val       = r_s3_val;
        n_s4_tok.rem       = w_acc_mag[icv_pkg::REM_W-1:0];
        n_s4_tok.dvs       = r_total;
        n_s4_tok.quo       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_tok <= '0;
        end else begin
            r_s4_tok <= n_s4_tok;
        end
    end

    // Divider chain, one quotient bit per cell, top bit flags saturation
    icv_pkg::t_tok w_chain [icv_pkg::QUO_W + 1];

    assign w_chain[0] = r_s4_tok;

    for (genvar g = 0; g < icv_pkg::QUO_W; g++) begin : g_cell
        icv_div_cell #(
            .SHIFT (icv_pkg::QUO_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g + 1])
        );
    end

    // Final value
    icv_pkg::t_tok w_last;
    icv_pkg::t_out w_res;
    logic          w_push, w_rel, w_pop;

    assign w_last = w_chain[icv_pkg::QUO_W];

    always_comb begin
        w_res.frame_end = w_last.frame_end;
        if (!w_last.use_div) begin
            w_res.out_pixel = w_last.val;
        end else if (w_last.is_zero) begin
            w_res.out_pixel = '0;
        end else if (w_last.quo[icv_pkg::QUO_W-1]) begin
            w_res.out_pixel = 8'hFF;
        end else begin
            w_res.out_pixel = w_last.quo[7:0];
        end
    end

    assign w_push = w_last.valid && w_last.emit;
    assign w_rel  = w_last.valid && !w_last.emit;
    assign w_pop  = o_out_valid && i_out_ready;

    icv_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // Beats in flight or buffered; never exceeds the buffer depth
    logic [icv_pkg::FIFO_AW:0] r_occ, n_occ;

    always_comb begin
        n_occ = r_occ + (icv_pkg::FIFO_AW + 1)'(w_acc)
                      - (icv_pkg::FIFO_AW + 1)'(w_rel)
                      - (icv_pkg::FIFO_AW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_in_ready = (r_occ < (icv_pkg::FIFO_AW + 1)'(icv_pkg::FIFO_DEPTH));

endmodule
`default_nettype wire

// ----- design/icv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module icv_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_ready,
    input wire icv_pkg::t_in              i_in_data,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire icv_pkg::t_out             o_out_data
);

    // A stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat withdrawn or changed while stalled");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // Reset leaves the input side open
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // Reset empties the output, so no result beat appears as reset is released
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid ##1 !o_out_valid)
        else $error("result beat appeared too soon after reset");

endmodule

bind image_convolution_3x3 icv_checker u_icv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ----- tb/tb_image_convolution_3x3.sv -----
`timescale 1ns / 1ps
module tb_image_convolution_3x3;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int   LINE_MAX  = 1024;

    // Expected-pixel tracker: mirrors the line stores, window and counters
    class conv_scoreboard;
        logic [icv_pkg::CFG_W-1:0] krow[3];
        logic [icv_pkg::GEO_W-1:0] width_reg, height_reg;
        logic [7:0]                upper[LINE_MAX];
        logic [7:0]                lower[LINE_MAX];
        logic [7:0]                win[9];
        int unsigned               col_cnt, row_cnt, pend;
        icv_pkg::t_out             expected_px[$];
        int                        errors, checked;

        function new();
            krow[0] = icv_pkg::KTOP_RST;
            krow[1] = icv_pkg::KMID_RST;
            krow[2] = icv_pkg::KBOT_RST;
            width_reg = icv_pkg::WIDTH_RST;
            height_reg = icv_pkg::HEIGHT_RST;
            foreach (upper[i]) begin
                upper[i] = '0;
                lower[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            pend = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [icv_pkg::IDX_W-1:0] idx,
                                logic [icv_pkg::CFG_W-1:0] v);
            case (idx)
                icv_pkg::CFG_KTOP:   krow[0] = v;
                icv_pkg::CFG_KMID:   krow[1] = v;
                icv_pkg::CFG_KBOT:   krow[2] = v;
                icv_pkg::CFG_WIDTH:  width_reg = v[icv_pkg::GEO_W-1:0];
                icv_pkg::CFG_HEIGHT: height_reg = v[icv_pkg::GEO_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            if (width_reg < icv_pkg::MIN_DIM) return 32'(icv_pkg::MIN_DIM);
            if (32'(width_reg) > LINE_MAX) return LINE_MAX;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_h();
            if (height_reg < icv_pkg::MIN_DIM) return 32'(icv_pkg::MIN_DIM);
            if (height_reg > icv_pkg::MAX_HEIGHT) return 32'(icv_pkg::MAX_HEIGHT);
            return 32'(height_reg);
        endfunction

        function int coef(int t);
            logic [7:0] b;
            b = 8'(krow[t / 3] >> (8 * (t % 3)));
            return int'($signed(b));
        endfunction

        // |weighted sum| / sum of |coefficients|, saturated to 8 bits
        function logic [7:0] filtered();
            int acc, total, k;
            acc = 0;
            total = 0;
            for (int t = 0; t < 9; t++) begin
                k = coef(t);
                acc += int'(win[t]) * k;
                total += (k < 0) ? -k : k;
            end
            if (total == 0) return 8'd0;
            if (acc < 0) acc = -acc;
            acc = acc / total;
            return (acc > 255) ? 8'd255 : acc[7:0];
        endfunction

        function void note_input(icv_pkg::t_in b);
            int unsigned   w, h, col, row;
            logic [7:0]    val;
            bit            emit;
            icv_pkg::t_out r;
            w = eff_w();
            h = eff_h();
            if (b.action == ACT_DRAIN) begin
                if (pend == 0) return;
                r.out_pixel = (pend > w) ? upper[w-1] : lower[w-pend];
                r.frame_end = (pend == 1);
                pend--;
                expected_px.push_back(r);
                return;
            end
            pend = 0;
            emit = 0;
            val = '0;
            col = (col_cnt >= LINE_MAX) ? 0 : col_cnt;
            row = row_cnt;
            // right border pixel of the row before last comes out at column zero
            if (row >= 2 && col == 0) begin
                val = upper[w-1];
                emit = 1;
            end
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = upper[col];
            win[5] = lower[col];
            win[8] = b.in_pixel;
            upper[col] = lower[col];
            lower[col] = b.in_pixel;
            if (row >= 1 && col >= 1) begin
                val = (row >= 2 && col >= 2) ? filtered() : win[4];
                emit = 1;
            end
            if (col + 1 >= w) begin
                col_cnt = 0;
                if (row + 1 >= h) begin
                    row_cnt = 0;
                    pend = w + 1;
                end else begin
                    row_cnt = row + 1;
                end
            end else begin
                col_cnt = col + 1;
            end
            if (emit) begin
                r.out_pixel = val;
                r.frame_end = 1'b0;
                expected_px.push_back(r);
            end
        endfunction

        function void check_result(icv_pkg::t_out got);
            icv_pkg::t_out exp_px;
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected beat pixel=%0d frame_end=%0b",
                         $realtime, got.out_pixel, got.frame_end);
                errors++;
                return;
            end
            exp_px = expected_px.pop_front();
            checked++;
            if (got.out_pixel !== exp_px.out_pixel) begin
                $display("%0t: out_pixel expected %0d actual %0d",
                         $realtime, exp_px.out_pixel, got.out_pixel);
                errors++;
            end
            if (got.frame_end !== exp_px.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b",
                         $realtime, exp_px.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [icv_pkg::IDX_W-1:0] i_cfg_index;
    logic [icv_pkg::CFG_W-1:0] i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_ready;
    icv_pkg::t_in              i_in_data;
    logic                      o_out_valid;
    logic                      i_out_ready;
    icv_pkg::t_out             o_out_data;

    conv_scoreboard sb;
    bit  gaps_on;
    bit  hold_req;
    int  burst_left;
    int  frames_sent;
    int  pixels_sent;

    image_convolution_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Register write, one cycle of write enable, then enable low before the task returns
    task automatic write_reg(logic [icv_pkg::IDX_W-1:0] idx, logic [icv_pkg::CFG_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    // Offer one beat, hold it until accepted, then maybe idle
    task automatic send_beat(logic act, logic [7:0] px);
        int n;
        i_in_valid <= 1'b1;
        i_in_data  <= '{action: act, in_pixel: px};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input('{action: act, in_pixel: px});
        if (act == ACT_PIXEL) pixels_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                n = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain(int n);
        for (int i = 0; i < n; i++) send_beat(ACT_DRAIN, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // One full frame of pixels with occasional stray drains; tail: 0 full, 1 part, 2 none
    task automatic send_frame(int tail);
        int unsigned w, h;
        w = sb.eff_w();
        h = sb.eff_h();
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 19) == 0) send_beat(ACT_DRAIN, 8'($urandom));
            send_beat(ACT_PIXEL, pick_pixel());
        end
        frames_sent++;
        case (tail)
            0: drain(w + 1 + $urandom_range(0, 2));
            1: drain($urandom_range(1, w));
            default: ;
        endcase
    endtask

    // Let every expected beat come out and the pipeline settle
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_px.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_kernel(logic [icv_pkg::CFG_W-1:0] t, logic [icv_pkg::CFG_W-1:0] m,
                              logic [icv_pkg::CFG_W-1:0] b);
        write_reg(icv_pkg::CFG_KTOP, t);
        write_reg(icv_pkg::CFG_KMID, m);
        write_reg(icv_pkg::CFG_KBOT, b);
    endtask

    task automatic set_geometry(logic [icv_pkg::CFG_W-1:0] w, logic [icv_pkg::CFG_W-1:0] h);
        write_reg(icv_pkg::CFG_WIDTH, w);
        write_reg(icv_pkg::CFG_HEIGHT, h);
    endtask

    // Receiver: checks accepted beats, stalls on a changing pattern
    initial begin
        int mode, mode_left, hold;
        mode = 0;
        mode_left = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (hold_req) begin
                hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int tail, nfr;
        logic [icv_pkg::CFG_W-1:0] k[3];
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        gaps_on = 0;
        hold_req = 0;
        burst_left = 1;
        frames_sent = 0;
        pixels_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest frame with default kernel, below-minimum geometry values
        set_geometry(24'd2, 24'd0);
        send_beat(ACT_DRAIN, 8'hA5);
        for (int i = 0; i < 9; i++) send_beat(ACT_PIXEL, (i % 2) ? 8'd255 : 8'd0);
        frames_sent++;
        drain(5);
        settle();

        // Directed: most negative kernel, saturated input, tail discarded by next frame
        set_kernel(24'h808080, 24'h808080, 24'h808080);
        for (int i = 0; i < 9; i++) send_beat(ACT_PIXEL, 8'd255);
        frames_sent++;
        send_beat(ACT_DRAIN, 8'd0);
        for (int i = 0; i < 9; i++) send_beat(ACT_PIXEL, (i == 4) ? 8'd0 : 8'd255);
        frames_sent++;
        drain(5);
        settle();

        // Random phases: small frames, mixed kernels, varied tails
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 5))
                0: begin k[0] = '0; k[1] = '0; k[2] = '0; end
                1: begin k[0] = 24'h7F7F7F; k[1] = 24'h7F7F7F; k[2] = 24'h7F7F7F; end
                2: begin
                    k[0] = icv_pkg::KTOP_RST;
                    k[1] = icv_pkg::KMID_RST;
                    k[2] = icv_pkg::KBOT_RST;
                end
                3: begin k[0] = 24'hFF00FF; k[1] = 24'h000800; k[2] = 24'hFF00FF; end
                default: begin
                    k[0] = 24'($urandom);
                    k[1] = 24'($urandom);
                    k[2] = 24'($urandom);
                end
            endcase
            set_kernel(k[0], k[1], k[2]);
            // One phase runs large frames under a long receiver hold so the input stalls
            if (p == 5) begin
                set_geometry(24'd12, 24'd10);
                hold_req = 1;
            end else begin
                set_geometry(24'($urandom_range(3, 12)), 24'($urandom_range(3, 10)));
            end
            gaps_on = $urandom_range(0, 3) != 0;
            nfr = $urandom_range(1, 3);
            for (int f = 0; f < nfr; f++) begin
                tail = (f == nfr - 1) ? 0 : $urandom_range(0, 2);
                send_frame(tail);
            end
            settle();
        end

        $display("Covered %0d frames, %0d pixels, %0d output beats checked",
                 frames_sent, pixels_sent, sb.checked);
        $display("Geometry from 3x3 up to 12 wide and 10 tall, kernels incl. zero sum");
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
